// File: rtl/pvt_pkg.sv
// Package for the pot value takeover block: sizes, codes, word types and the
// sequencer state type. Used by every other file of the block.
package pvt_pkg;

    localparam int NUM_POTS = 8;
    localparam int ADC_FULL = 4095;
    localparam int CH_W     = 3;
    localparam int RAW_W    = 12;
    localparam int VAL_W    = 16;
    localparam int ST_W     = 13;
    localparam int DVD_W    = 34;
    localparam int DVS_W    = 17;
    localparam int MULA_W   = 22;
    localparam int MULB_W   = 18;
    localparam int CNT_W    = $clog2(DVD_W + 1);

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_SEED    = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;

    localparam logic REG_MOVE_THR = 1'b0;
    localparam logic REG_ANCHOR   = 1'b1;

    localparam int FLAG_EN  = 0;
    localparam int FLAG_ACT = 1;
    localparam int FLAG_ANC = 2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [CH_W-1:0]         channel;
        logic [RAW_W-1:0]        raw_sample;
        logic signed [VAL_W-1:0] seed_value;
        logic signed [VAL_W-1:0] seed_min;
        logic signed [VAL_W-1:0] seed_max;
        logic                    seed_mode;
        logic [15:0]             seed_steps;
    } pvt_item_t;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [VAL_W-1:0] value;
        logic                    moved;
        logic                    active;
        logic                    anchored;
        logic                    enabled;
    } pvt_res_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_DISPATCH, S_ST_DIV, S_ST_WAIT, S_R_DIV, S_R_WAIT,
        S_A_MUL, S_A_DIV, S_A_WAIT, S_A_MUL2, S_A_DIV2, S_A_WAIT2,
        S_P_MUL, S_P_DIV, S_P_WAIT, S_T_MUL, S_T_DIV, S_T_WAIT,
        S_WRITE, S_DONE
    } pvt_state_t;

    function automatic logic signed [VAL_W-1:0] pvt_sat16(input logic signed [23:0] x);
        logic signed [VAL_W-1:0] r;
        if (x > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (x < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/pvt_if.sv
// Handshake interfaces of the pot value takeover block: input items, result
// words and configuration writes. Depends on pvt_pkg.
interface pvt_in_if import pvt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [CH_W-1:0]         channel;
    logic [RAW_W-1:0]        raw_sample;
    logic signed [VAL_W-1:0] seed_value;
    logic signed [VAL_W-1:0] seed_min;
    logic signed [VAL_W-1:0] seed_max;
    logic                    seed_mode;
    logic [15:0]             seed_steps;
    modport source (output valid, kind, channel, raw_sample, seed_value, seed_min,
                    seed_max, seed_mode, seed_steps, input ready);
    modport sink (input valid, kind, channel, raw_sample, seed_value, seed_min,
                  seed_max, seed_mode, seed_steps, output ready);
endinterface

interface pvt_out_if import pvt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         out_channel;
    logic signed [VAL_W-1:0] value;
    logic                    moved;
    logic                    active;
    logic                    anchored;
    logic                    enabled;
    modport source (output valid, out_channel, value, moved, active, anchored, enabled,
                    input ready);
    modport sink (input valid, out_channel, value, moved, active, anchored, enabled,
                  output ready);
endinterface

interface pvt_cfg_if import pvt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             index;
    logic [RAW_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pvt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pvt_pkg.
module pvt_div import pvt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/pvt_seq.sv
// Item sequencer with the per-channel store, the shared multiplier and the
// serial divider. Depends on pvt_pkg and pvt_div.
module pvt_seq import pvt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pvt_item_t        item,
    input  logic [RAW_W-1:0] move_thr,
    input  logic [RAW_W-1:0] anchor_win,
    output logic             res_valid,
    input  logic             res_ready,
    output pvt_res_t         res
);

    pvt_state_t state_reg, state_next;

    logic signed [VAL_W-1:0] cur_value_reg  [NUM_POTS];
    logic signed [VAL_W-1:0] low_bound_reg  [NUM_POTS];
    logic signed [VAL_W-1:0] high_bound_reg [NUM_POTS];
    logic                    is_rel_reg     [NUM_POTS];
    logic [ST_W-1:0]         step_size_reg  [NUM_POTS];
    logic [RAW_W-1:0]        base_read_reg  [NUM_POTS];
    logic signed [VAL_W-1:0] delta_acc_reg  [NUM_POTS];
    logic [2:0]              flags_arr_reg  [NUM_POTS];

    pvt_item_t               item_reg;
    logic signed [VAL_W-1:0] v_reg, lo_reg, hi_reg, acc_reg, m_reg;
    logic                    rel_reg, sign_reg, moved_reg;
    logic [ST_W-1:0]         st_reg;
    logic [RAW_W-1:0]        base_reg;
    logic [2:0]              flags_reg;
    logic [DVS_W-1:0]        range_reg;
    logic signed [MULA_W-1:0] vd_reg;
    logic signed [DVD_W-1:0] prod_reg;

    logic                    bad_ch;
    logic signed [13:0]      raw_d;
    logic [12:0]             abs_d;
    logic signed [VAL_W-1:0] acc_sat, mx_c;
    logic [15:0]             steps_calc;
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [MULA_W+MULB_W-1:0] mul_p;
    logic [DVD_W-1:0]        prod_mag, div_dvd, div_q;
    logic [DVS_W-1:0]        div_dvs, div_r;
    logic                    div_start, div_done;
    logic signed [17:0]      q_rel;
    logic signed [18:0]      v_plus_q;
    logic signed [MULA_W-1:0] vd;
    logic signed [22:0]      v_plus_vd, nv_abs;
    logic signed [22:0]      back_q;
    logic signed [17:0]      m_full;
    logic signed [16:0]      m_diff;
    logic [16:0]             d_abs, th;

    pvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        bad_ch     = {1'b0, item_reg.channel} >= (CH_W+1)'(NUM_POTS);
        raw_d      = $signed({2'b0, item_reg.raw_sample}) - $signed({2'b0, base_reg});
        abs_d      = raw_d[13] ? 13'(-raw_d) : 13'(raw_d);
        acc_sat    = pvt_sat16(24'(acc_reg) + 24'(raw_d));
        mx_c       = (item_reg.seed_max < item_reg.seed_min) ? item_reg.seed_min
                                                             : item_reg.seed_max;
        steps_calc = (item_reg.seed_steps != 16'd0) ? item_reg.seed_steps
                   : 16'(mx_c - item_reg.seed_min + 16'sd1);
        prod_mag   = prod_reg[DVD_W-1] ? DVD_W'(-prod_reg) : DVD_W'(prod_reg);
        mul_p      = mul_a * mul_b;
        q_rel      = sign_reg ? -$signed({1'b0, div_q[16:0]}) : $signed({1'b0, div_q[16:0]});
        v_plus_q   = 19'(v_reg) + 19'(q_rel);
        vd         = sign_reg ? -$signed({1'b0, div_q[MULA_W-2:0]})
                              : $signed({1'b0, div_q[MULA_W-2:0]});
        v_plus_vd  = 23'(v_reg) + 23'(vd);
        if (v_plus_vd < 23'(lo_reg))
        begin
            nv_abs = 23'(lo_reg);
        end
        else if (v_plus_vd > 23'(hi_reg))
        begin
            nv_abs = 23'(hi_reg);
        end
        else
        begin
            nv_abs = v_plus_vd;
        end
        back_q     = sign_reg ? -$signed(div_q[22:0]) : $signed(div_q[22:0]);
        m_full     = 18'(lo_reg) + $signed({1'b0, div_q[16:0]});
        m_diff     = 17'(m_reg) - 17'(v_reg);
        d_abs      = m_diff[16] ? 17'(-m_diff) : 17'(m_diff);
        th         = (div_q[16:0] == 17'd0) ? 17'd1 : div_q[16:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_LOAD;
            S_LOAD:     state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (bad_ch)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (item_reg.kind)
                        KIND_SEED:
                            state_next = (item_reg.seed_mode && steps_calc != 16'd0)
                                       ? S_ST_DIV : S_WRITE;
                        KIND_SAMPLE:
                        begin
                            if (!flags_reg[FLAG_EN] || !flags_reg[FLAG_ACT])
                                state_next = S_WRITE;
                            else if (rel_reg)
                                state_next = S_R_DIV;
                            else if (!flags_reg[FLAG_ANC])
                                state_next = S_A_MUL;
                            else
                                state_next = S_P_MUL;
                        end
                        default:    state_next = S_WRITE;
                    endcase
                end
            end
            S_ST_DIV:   state_next = S_ST_WAIT;
            S_ST_WAIT:  if (div_done) state_next = S_WRITE;
            S_R_DIV:    state_next = S_R_WAIT;
            S_R_WAIT:   if (div_done) state_next = S_WRITE;
            S_A_MUL:    state_next = S_A_DIV;
            S_A_DIV:    state_next = S_A_WAIT;
            S_A_WAIT:   if (div_done) state_next = (vd == '0) ? S_P_MUL : S_A_MUL2;
            S_A_MUL2:   state_next = S_A_DIV2;
            S_A_DIV2:   state_next = S_A_WAIT2;
            S_A_WAIT2:  if (div_done) state_next = S_P_MUL;
            S_P_MUL:    state_next = S_P_DIV;
            S_P_DIV:    state_next = S_P_WAIT;
            S_P_WAIT:   if (div_done) state_next = flags_reg[FLAG_ANC] ? S_WRITE : S_T_MUL;
            S_T_MUL:    state_next = S_T_DIV;
            S_T_DIV:    state_next = S_T_WAIT;
            S_T_WAIT:   if (div_done) state_next = S_WRITE;
            S_WRITE:    state_next = S_DONE;
            S_DONE:     if (res_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        res_valid = state_reg == S_DONE;
        div_start = 1'b0;
        div_dvd   = prod_mag;
        div_dvs   = DVS_W'(ADC_FULL);
        mul_a     = MULA_W'(acc_reg);
        mul_b     = $signed({1'b0, range_reg});
        case (state_reg)
            S_ST_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(ADC_FULL + 1);
                div_dvs   = DVS_W'(steps_calc);
            end
            S_R_DIV:
            begin
                div_start = 1'b1;
                div_dvd   = acc_reg[VAL_W-1] ? DVD_W'(-17'(acc_reg)) : DVD_W'(acc_reg);
                div_dvs   = DVS_W'(st_reg);
            end
            S_A_DIV, S_T_DIV:
            begin
                div_start = 1'b1;
            end
            S_A_DIV2:
            begin
                div_start = 1'b1;
                div_dvs   = range_reg;
            end
            S_P_DIV:
            begin
                div_start = 1'b1;
                div_dvs   = DVS_W'(ADC_FULL + 1);
            end
            S_A_MUL2:
            begin
                mul_a = vd_reg;
                mul_b = MULB_W'(ADC_FULL);
            end
            S_P_MUL:
            begin
                mul_a = MULA_W'({1'b0, item_reg.raw_sample} + 13'd1);
            end
            S_T_MUL:
            begin
                mul_a = MULA_W'(anchor_win);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.out_channel = item_reg.channel;
        res.value       = bad_ch ? '0 : v_reg;
        res.moved       = bad_ch ? 1'b0 : moved_reg;
        res.active      = bad_ch ? 1'b0 : flags_reg[FLAG_ACT];
        res.anchored    = bad_ch ? 1'b0 : flags_reg[FLAG_ANC];
        res.enabled     = bad_ch ? 1'b0 : flags_reg[FLAG_EN];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_POTS; i++)
            begin
                cur_value_reg[i]  <= '0;
                low_bound_reg[i]  <= '0;
                high_bound_reg[i] <= 16'sd100;
                is_rel_reg[i]     <= 1'b0;
                step_size_reg[i]  <= ST_W'(1);
                base_read_reg[i]  <= '0;
                delta_acc_reg[i]  <= '0;
                flags_arr_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WRITE)
            begin
                cur_value_reg[item_reg.channel]  <= v_reg;
                low_bound_reg[item_reg.channel]  <= lo_reg;
                high_bound_reg[item_reg.channel] <= hi_reg;
                is_rel_reg[item_reg.channel]     <= rel_reg;
                step_size_reg[item_reg.channel]  <= st_reg;
                base_read_reg[item_reg.channel]  <= base_reg;
                delta_acc_reg[item_reg.channel]  <= acc_reg;
                flags_arr_reg[item_reg.channel]  <= flags_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg  <= item;
                moved_reg <= 1'b0;
            end
            S_LOAD:
            begin
                v_reg     <= cur_value_reg[item_reg.channel];
                lo_reg    <= low_bound_reg[item_reg.channel];
                hi_reg    <= high_bound_reg[item_reg.channel];
                rel_reg   <= is_rel_reg[item_reg.channel];
                st_reg    <= step_size_reg[item_reg.channel];
                base_reg  <= base_read_reg[item_reg.channel];
                acc_reg   <= delta_acc_reg[item_reg.channel];
                flags_reg <= flags_arr_reg[item_reg.channel];
            end
            S_DISPATCH:
            begin
                range_reg <= DVS_W'(17'(hi_reg) - 17'(lo_reg));
                case (item_reg.kind)
                    KIND_SEED:
                    begin
                        v_reg     <= item_reg.seed_value;
                        lo_reg    <= item_reg.seed_min;
                        hi_reg    <= mx_c;
                        rel_reg   <= item_reg.seed_mode;
                        flags_reg <= 3'b001;
                        acc_reg   <= '0;
                        base_reg  <= item_reg.raw_sample;
                        if (item_reg.seed_mode)
                        begin
                            st_reg <= ST_W'(1);
                        end
                    end
                    KIND_DISABLE:
                    begin
                        flags_reg <= '0;
                    end
                    KIND_SAMPLE:
                    begin
                        if (flags_reg[FLAG_EN] && !flags_reg[FLAG_ACT])
                        begin
                            if (abs_d >= {1'b0, move_thr})
                            begin
                                flags_reg[FLAG_ACT] <= 1'b1;
                                base_reg            <= item_reg.raw_sample;
                            end
                        end
                        else if (flags_reg[FLAG_EN] && (rel_reg || !flags_reg[FLAG_ANC]))
                        begin
                            acc_reg  <= acc_sat;
                            base_reg <= item_reg.raw_sample;
                        end
                    end
                    default:
                    begin
                        moved_reg <= 1'b0;
                    end
                endcase
            end
            S_ST_WAIT:
            begin
                if (div_done)
                begin
                    st_reg <= (div_q == '0) ? ST_W'(1) : div_q[ST_W-1:0];
                end
            end
            S_R_DIV, S_A_DIV, S_A_DIV2:
            begin
                sign_reg <= (state_reg == S_R_DIV) ? acc_reg[VAL_W-1] : prod_reg[DVD_W-1];
            end
            S_R_WAIT:
            begin
                if (div_done)
                begin
                    acc_reg <= sign_reg ? -$signed({3'b0, div_r[12:0]})
                                        : $signed({3'b0, div_r[12:0]});
                    if (q_rel > 18'sd0 && v_reg < hi_reg)
                    begin
                        v_reg     <= (v_plus_q > 19'(hi_reg)) ? hi_reg : v_plus_q[VAL_W-1:0];
                        moved_reg <= 1'b1;
                    end
                    else if (q_rel < 18'sd0 && v_reg > lo_reg)
                    begin
                        v_reg     <= (v_plus_q < 19'(lo_reg)) ? lo_reg : v_plus_q[VAL_W-1:0];
                        moved_reg <= 1'b1;
                    end
                end
            end
            S_A_MUL, S_A_MUL2, S_P_MUL, S_T_MUL:
            begin
                prod_reg <= mul_p[DVD_W-1:0];
            end
            S_A_WAIT:
            begin
                if (div_done)
                begin
                    vd_reg <= vd;
                    if (vd != '0 && nv_abs != 23'(v_reg))
                    begin
                        v_reg     <= nv_abs[VAL_W-1:0];
                        moved_reg <= 1'b1;
                    end
                end
            end
            S_A_WAIT2:
            begin
                if (div_done)
                begin
                    acc_reg <= pvt_sat16(24'(acc_reg) - 24'(back_q));
                end
            end
            S_P_WAIT:
            begin
                if (div_done)
                begin
                    m_reg <= m_full[VAL_W-1:0];
                    if (flags_reg[FLAG_ANC] && m_full[VAL_W-1:0] != v_reg)
                    begin
                        v_reg     <= m_full[VAL_W-1:0];
                        moved_reg <= 1'b1;
                    end
                end
            end
            S_T_WAIT:
            begin
                if (div_done && d_abs <= th)
                begin
                    flags_reg[FLAG_ANC] <= 1'b1;
                    acc_reg             <= '0;
                end
            end
            default:
            begin
                moved_reg <= moved_reg;
            end
        endcase
    end

endmodule

// File: rtl/pot_value_takeover_top.sv
// Top level of the pot value takeover block: configuration registers, the
// result output register and the item sequencer. Depends on pvt_pkg, pvt_if, pvt_seq.
//
// Each input word yields exactly one result word on the output channel. Disable,
// absolute seed and samples that need no arithmetic use neither the multiplier
// nor the divider. A relative seed with a nonzero step count, a relative step and
// an anchored absolute sample use the divider once; an absolute sample before
// anchoring uses it three or four times. The bit-serial divider produces one
// quotient bit per cycle over 34 bits. A finished result waits in the output
// register while the next word is already taken in.
module pot_value_takeover_top import pvt_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    pvt_in_if.sink    in_ch,
    pvt_out_if.source out_ch,
    pvt_cfg_if.sink   cfg
);

    logic [RAW_W-1:0] move_thr_reg, anchor_win_reg;
    logic             out_valid_reg;
    pvt_res_t         out_reg;
    pvt_item_t        item;
    pvt_res_t         res;
    logic             core_ready, res_valid, res_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_thr_reg   <= RAW_W'(32);
            anchor_win_reg <= RAW_W'(64);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MOVE_THR: move_thr_reg   <= cfg.data;
                REG_ANCHOR:   anchor_win_reg <= cfg.data;
                default:      move_thr_reg   <= move_thr_reg;
            endcase
        end
    end

    always_comb
    begin
        item.kind       = in_ch.kind;
        item.channel    = in_ch.channel;
        item.raw_sample = in_ch.raw_sample;
        item.seed_value = in_ch.seed_value;
        item.seed_min   = in_ch.seed_min;
        item.seed_max   = in_ch.seed_max;
        item.seed_mode  = in_ch.seed_mode;
        item.seed_steps = in_ch.seed_steps;
    end

    assign in_ch.ready = core_ready;
    assign res_ready   = !out_valid_reg || out_ch.ready;

    pvt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (core_ready),
        .item       (item),
        .move_thr   (move_thr_reg),
        .anchor_win (anchor_win_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_channel = out_reg.out_channel;
    assign out_ch.value       = out_reg.value;
    assign out_ch.moved       = out_reg.moved;
    assign out_ch.active      = out_reg.active;
    assign out_ch.anchored    = out_reg.anchored;
    assign out_ch.enabled     = out_reg.enabled;

    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid_reg)
        else $error("result word was not captured by the output register");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && core_ready) |=> !core_ready)
        else $error("sequencer took a second word while busy");

    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.enabled || (!out_reg.active && !out_reg.anchored)))
        else $error("disabled channel reported as active or anchored");

    a_moved_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.moved) |-> (out_reg.active && out_reg.enabled))
        else $error("value moved on a channel that is not active");

endmodule
